// ===== rtl/lzo_pkg.sv =====
`default_nettype none

package lzo_pkg;

    // Default size of the layer pool.
    localparam int MAX_LAYERS_DEF = 256;

    // Widths of the transfer fields.
    localparam int OP_W   = 2;
    localparam int SLOT_W = 8;
    localparam int HREQ_W = 10;
    localparam int HOUT_W = 9;
    localparam int VIS_W  = 9;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC      = 2'd0,
        OP_SET_HEIGHT = 2'd1,
        OP_FREE       = 2'd2,
        OP_QUERY      = 2'd3
    } t_op;

endpackage

`default_nettype wire

// ===== rtl/lzo_if.sv =====
`default_nettype none

interface lzo_in_if;
    import lzo_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [SLOT_W-1:0]        slot;
    logic signed [HREQ_W-1:0] height_req;

    modport source (output valid, output op, output slot, output height_req, input ready);
    modport sink   (input valid, input op, input slot, input height_req, output ready);
endinterface

interface lzo_out_if;
    import lzo_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [SLOT_W-1:0]        slot_out;
    logic                     status;
    logic signed [HOUT_W-1:0] height_out;
    logic [VIS_W-1:0]         visible_count;

    modport source (output valid, output slot_out, output status, output height_out,
                    output visible_count, input ready);
    modport sink   (input valid, input slot_out, input status, input height_out,
                    input visible_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/lzo_ram.sv =====
`default_nettype none

module lzo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/layer_z_order_manager_unit.sv =====
`default_nettype none

// Layer stacking-order manager. Each input transfer is one operation (allocate, set height,
// free or query) and yields exactly one result transfer. Slot state (in-use flag and height)
// lives in one memory and the stacking order in a second; both have a registered read. After
// reset a clearing pass marks every slot free, during which no input is taken. A query, or an
// operation on a slot that is not in use, goes from the slot lookup straight to the result.
// Allocate scans the slot memory one entry per cycle from slot zero until it finds a free slot
// or reaches the end of the pool. Set height and free shift the order memory one entry per
// cycle for each layer that moves. A new operation is taken while the previous result still
// waits in the output register.
module layer_z_order_manager_unit #(
    parameter int MAX_LAYERS = lzo_pkg::MAX_LAYERS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lzo_in_if.sink    i_in,
    lzo_out_if.source o_out
);
    import lzo_pkg::*;

    localparam int AW  = $clog2(MAX_LAYERS);
    localparam int HW  = AW + 1;
    localparam int SMW = HW + 1;
    localparam int CW  = ((HW > HREQ_W) ? HW : HREQ_W) + 1;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_LOOK  = 6'b000100,
        S_ALLOC = 6'b001000,
        S_SHIFT = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [AW:0] r_ra, n_ra;
    logic r_pend, n_pend;
    logic [AW-1:0] r_pend_dst, n_pend_dst;
    logic [AW:0] r_cnt, n_cnt;
    logic signed [HW-1:0] r_top, n_top;
    logic r_o_valid, n_o_valid;

    t_op r_op, n_op;
    logic [AW-1:0] r_slot, n_slot;
    logic r_slot_ok, n_slot_ok;
    logic signed [HREQ_W-1:0] r_req, n_req;
    logic signed [HW-1:0] r_h, n_h;
    logic [HW-1:0] r_d, n_d;
    logic r_dir, n_dir;
    logic signed [HW-1:0] r_top_n, n_top_n;
    logic r_wr_slot, n_wr_slot;
    logic r_wr_order, n_wr_order;
    logic [SMW-1:0] r_slot_wdata, n_slot_wdata;
    logic r_status, n_status;
    logic signed [HW-1:0] r_hout, n_hout;
    logic [SLOT_W-1:0] r_o_slot, n_o_slot;
    logic r_o_status, n_o_status;
    logic [HOUT_W-1:0] r_o_hout, n_o_hout;
    logic [VIS_W-1:0] r_o_vis, n_o_vis;

    logic sm_we;
    logic [AW-1:0] sm_waddr, sm_raddr;
    logic [SMW-1:0] sm_wdata, sm_rdata;
    logic om_we;
    logic [AW-1:0] om_waddr, om_raddr, om_wdata, om_rdata;

    logic [10:0] w_in_slot_x;
    logic [AW-1:0] w_in_addr;
    logic w_in_ok;
    logic w_used, w_valid;
    logic signed [HW-1:0] w_old, w_h;
    logic w_old_shown, w_h_shown;
    logic signed [CW-1:0] w_top_x, w_req_x, w_lim, w_hc, w_neg1;
    logic [HW-1:0] w_d0;
    logic w_dir;
    logic [AW:0] w_cnt;
    logic signed [HW-1:0] w_top_nx;
    logic w_wr_order;
    logic [HW-1:0] w_step;
    logic w_issue, w_scan_more;
    logic [AW+SLOT_W-1:0] w_slot_x;
    logic [HW+HOUT_W-1:0] w_hout_x;
    logic [AW:0] w_vis;
    logic [AW+VIS_W:0] w_vis_x;

    lzo_ram #(.WIDTH(SMW), .DEPTH(MAX_LAYERS)) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (sm_we),
        .i_waddr (sm_waddr),
        .i_wdata (sm_wdata),
        .i_raddr (sm_raddr),
        .o_rdata (sm_rdata)
    );

    lzo_ram #(.WIDTH(AW), .DEPTH(MAX_LAYERS)) u_order_mem (
        .i_clk   (i_clk),
        .i_we    (om_we),
        .i_waddr (om_waddr),
        .i_wdata (om_wdata),
        .i_raddr (om_raddr),
        .o_rdata (om_rdata)
    );

    assign w_in_slot_x = {3'd0, i_in.slot};
    assign w_in_addr   = w_in_slot_x[AW-1:0];
    assign w_in_ok     = (w_in_slot_x < 11'(MAX_LAYERS));

    // Height clamp and the plan of the order shift, worked out from the slot entry just read.
    assign w_used      = sm_rdata[SMW-1];
    assign w_valid     = r_slot_ok && w_used;
    assign w_old       = $signed(sm_rdata[HW-1:0]);
    assign w_old_shown = !w_old[HW-1];
    assign w_top_x     = $signed({{(CW-HW){r_top[HW-1]}}, r_top});
    assign w_req_x     = $signed({{(CW-HREQ_W){r_req[HREQ_W-1]}}, r_req});
    assign w_neg1      = '1;
    assign w_lim       = w_old_shown ? w_top_x : (w_top_x + $signed(CW'(1)));
    assign w_hc        = (w_req_x > w_lim) ? w_lim : ((w_req_x < w_neg1) ? w_neg1 : w_req_x);
    assign w_h         = (r_op == OP_FREE) ? '1 : $signed(w_hc[HW-1:0]);
    assign w_h_shown   = !w_h[HW-1];

    always_comb begin
        w_d0       = w_old;
        w_dir      = 1'b0;
        w_cnt      = '0;
        w_top_nx   = r_top;
        w_wr_order = 1'b0;
        if (w_old > w_h) begin
            if (w_h_shown) begin
                w_cnt      = w_old - w_h;
                w_wr_order = 1'b1;
            end else begin
                // Hiding: the layers above close the gap downwards.
                w_dir    = 1'b1;
                w_cnt    = r_top - w_old;
                w_top_nx = r_top - HW'(1);
            end
        end else if (w_old < w_h) begin
            w_wr_order = 1'b1;
            if (w_old_shown) begin
                w_dir = 1'b1;
                w_cnt = w_h - w_old;
            end else begin
                // Showing: the layers at the target height and above move up by one.
                w_d0     = r_top + HW'(1);
                w_cnt    = r_top + HW'(1) - w_h;
                w_top_nx = r_top + HW'(1);
            end
        end
    end

    assign w_step      = r_dir ? (r_d + HW'(1)) : (r_d - HW'(1));
    assign w_issue     = (r_cnt != '0);
    assign w_scan_more = (r_ra < (AW+1)'(MAX_LAYERS));

    assign w_slot_x = {{SLOT_W{1'b0}}, r_slot};
    assign w_hout_x = {{HOUT_W{r_hout[HW-1]}}, r_hout};
    assign w_vis    = r_top_n + HW'(1);
    assign w_vis_x  = {{VIS_W{1'b0}}, w_vis};

    always_comb begin
        n_state      = r_state;
        n_ra         = r_ra;
        n_pend       = r_pend;
        n_pend_dst   = r_pend_dst;
        n_cnt        = r_cnt;
        n_top        = r_top;
        n_o_valid    = r_o_valid;
        n_op         = r_op;
        n_slot       = r_slot;
        n_slot_ok    = r_slot_ok;
        n_req        = r_req;
        n_h          = r_h;
        n_d          = r_d;
        n_dir        = r_dir;
        n_top_n      = r_top_n;
        n_wr_slot    = r_wr_slot;
        n_wr_order   = r_wr_order;
        n_slot_wdata = r_slot_wdata;
        n_status     = r_status;
        n_hout       = r_hout;
        n_o_slot     = r_o_slot;
        n_o_status   = r_o_status;
        n_o_hout     = r_o_hout;
        n_o_vis      = r_o_vis;

        sm_we    = 1'b0;
        sm_waddr = r_slot;
        sm_wdata = r_slot_wdata;
        sm_raddr = w_in_addr;
        om_we    = 1'b0;
        om_waddr = r_pend_dst;
        om_wdata = om_rdata;
        om_raddr = w_step[AW-1:0];

        if (r_o_valid && o_out.ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                sm_we    = 1'b1;
                sm_waddr = r_ra[AW-1:0];
                sm_wdata = '0;
                n_ra     = r_ra + (AW+1)'(1);
                if (r_ra == (AW+1)'(MAX_LAYERS - 1)) begin
                    n_ra    = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op      = t_op'(i_in.op);
                    n_slot    = w_in_addr;
                    n_slot_ok = w_in_ok;
                    n_req     = i_in.height_req;
                    n_ra      = '0;
                    n_pend    = 1'b0;
                    n_state   = (t_op'(i_in.op) == OP_ALLOC) ? S_ALLOC : S_LOOK;
                end
            end
            S_LOOK: begin
                n_status   = 1'b0;
                n_hout     = '1;
                n_top_n    = r_top;
                n_wr_slot  = 1'b0;
                n_wr_order = 1'b0;
                n_cnt      = '0;
                n_pend     = 1'b0;
                n_h        = w_h;
                n_state    = S_FIN;
                if (w_valid) begin
                    unique case (r_op)
                        OP_QUERY: begin
                            n_hout = w_old;
                        end
                        OP_SET_HEIGHT, OP_FREE: begin
                            n_hout       = w_h;
                            n_wr_slot    = 1'b1;
                            n_slot_wdata = {(r_op == OP_SET_HEIGHT), w_h};
                            n_d          = w_d0;
                            n_dir        = w_dir;
                            n_cnt        = w_cnt;
                            n_top_n      = w_top_nx;
                            n_wr_order   = w_wr_order;
                            n_state      = S_SHIFT;
                        end
                        OP_ALLOC: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                sm_raddr = r_ra[AW-1:0];
                if (r_pend && !w_used) begin
                    n_slot       = r_pend_dst;
                    n_status     = 1'b0;
                    n_hout       = '1;
                    n_top_n      = r_top;
                    n_wr_slot    = 1'b1;
                    n_wr_order   = 1'b0;
                    n_slot_wdata = {1'b1, {HW{1'b1}}};
                    n_pend       = 1'b0;
                    n_state      = S_FIN;
                end else if (!r_pend && !w_scan_more) begin
                    n_slot     = '0;
                    n_status   = 1'b1;
                    n_hout     = '1;
                    n_top_n    = r_top;
                    n_wr_slot  = 1'b0;
                    n_wr_order = 1'b0;
                    n_state    = S_FIN;
                end else begin
                    n_pend     = w_scan_more;
                    n_pend_dst = r_ra[AW-1:0];
                    if (w_scan_more) begin
                        n_ra = r_ra + (AW+1)'(1);
                    end
                end
            end
            S_SHIFT: begin
                // The read runs one entry ahead of the write, in the direction of travel.
                n_pend = w_issue;
                if (w_issue) begin
                    n_d        = w_step;
                    n_cnt      = r_cnt - (AW+1)'(1);
                    n_pend_dst = r_d[AW-1:0];
                end
                if (r_pend) begin
                    om_we    = 1'b1;
                    om_waddr = r_pend_dst;
                    om_wdata = om_rdata;
                    sm_we    = 1'b1;
                    sm_waddr = om_rdata;
                    sm_wdata = {1'b1, 1'b0, r_pend_dst};
                end
                if (!w_issue && !r_pend) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_o_valid || o_out.ready) begin
                    sm_we      = r_wr_slot;
                    sm_waddr   = r_slot;
                    sm_wdata   = r_slot_wdata;
                    om_we      = r_wr_order;
                    om_waddr   = r_h[AW-1:0];
                    om_wdata   = r_slot;
                    n_top      = r_top_n;
                    n_o_valid  = 1'b1;
                    n_o_slot   = w_slot_x[SLOT_W-1:0];
                    n_o_status = r_status;
                    n_o_hout   = w_hout_x[HOUT_W-1:0];
                    n_o_vis    = w_vis_x[VIS_W-1:0];
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_ra      <= '0;
            r_pend    <= 1'b0;
            r_cnt     <= '0;
            r_top     <= '1;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ra      <= n_ra;
            r_pend    <= n_pend;
            r_cnt     <= n_cnt;
            r_top     <= n_top;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_dst   <= n_pend_dst;
        r_op         <= n_op;
        r_slot       <= n_slot;
        r_slot_ok    <= n_slot_ok;
        r_req        <= n_req;
        r_h          <= n_h;
        r_d          <= n_d;
        r_dir        <= n_dir;
        r_top_n      <= n_top_n;
        r_wr_slot    <= n_wr_slot;
        r_wr_order   <= n_wr_order;
        r_slot_wdata <= n_slot_wdata;
        r_status     <= n_status;
        r_hout       <= n_hout;
        r_o_slot     <= n_o_slot;
        r_o_status   <= n_o_status;
        r_o_hout     <= n_o_hout;
        r_o_vis      <= n_o_vis;
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_o_valid;
    assign o_out.slot_out       = r_o_slot;
    assign o_out.status         = r_o_status;
    assign o_out.height_out     = $signed(r_o_hout);
    assign o_out.visible_count  = r_o_vis;

endmodule

`default_nettype wire

// ===== rtl/lzo_chk.sv =====
`default_nettype none

module lzo_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [lzo_pkg::SLOT_W-1:0]       i_slot_out,
    input logic                             i_status,
    input logic [lzo_pkg::HOUT_W-1:0]       i_height_out,
    input logic [lzo_pkg::VIS_W-1:0]        i_visible_count
);
    import lzo_pkg::*;

    logic [2:0]       r_outstanding;
    logic [VIS_W-1:0] r_last_vis;
    logic             w_in_xfer, w_out_xfer;

    assign w_in_xfer  = i_in_valid && i_in_ready;
    assign w_out_xfer = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
            r_last_vis    <= '0;
        end else begin
            r_outstanding <= r_outstanding + 3'(w_in_xfer) - 3'(w_out_xfer);
            if (w_out_xfer) begin
                r_last_vis <= i_visible_count;
            end
        end
    end

    // A failed allocate reports slot zero and a hidden height.
    a_fail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status |-> i_slot_out == '0 && i_height_out == '1)
        else $error("failed allocate carries a slot or a height");

    // One operation shows or hides at most one layer.
    a_vis_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer |-> i_visible_count == r_last_vis
                    || i_visible_count == r_last_vis + VIS_W'(1)
                    || i_visible_count + VIS_W'(1) == r_last_vis)
        else $error("visible count moved by more than one");

    // Every result belongs to an accepted operation, and at most two are in flight.
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_outstanding != 3'd0 && r_outstanding <= 3'd2)
        else $error("result without an operation, or too many in flight");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_slot_out)
            && $stable(i_status) && $stable(i_height_out) && $stable(i_visible_count))
        else $error("stalled result changed");

endmodule

bind layer_z_order_manager_unit lzo_chk u_lzo_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_slot_out      (o_out.slot_out),
    .i_status        (o_out.status),
    .i_height_out    (o_out.height_out),
    .i_visible_count (o_out.visible_count)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
    import lzo_pkg::*;

    localparam int POOL_SIZE   = MAX_LAYERS_DEF;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int STALL_LEN   = 400;
    localparam int PRINT_CAP   = 30;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              status;
        logic [HOUT_W-1:0] height;
        logic [VIS_W-1:0]  visible;
    } t_layer_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lzo_in_if  op_if ();
    lzo_out_if res_if ();

    layer_z_order_manager_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_if),
        .o_out   (res_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the layer pool and the stacking order.
    bit pool_used [POOL_SIZE];
    int layer_height [POOL_SIZE];
    int stack_order [POOL_SIZE];
    int top_layer = -1;

    t_layer_result pending_results [$];
    t_layer_result oldest_expected;
    int mismatch_count = 0;
    int unsigned cycle_count = 0;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    bit stall_request = 1'b0;

    function automatic int wrap_idx(int k);
        return (k < 0) ? 0 : k % POOL_SIZE;
    endfunction

    function automatic void move_layer(int s, int h);
        int prev;
        int k;
        prev = layer_height[s];
        if (prev >= 0) begin
            if (h > top_layer) h = top_layer;
        end else if (h > top_layer + 1) begin
            h = top_layer + 1;
        end
        if (h < -1) h = -1;
        layer_height[s] = h;
        if (prev > h) begin
            if (h >= 0) begin
                for (k = prev; k > h; k--) begin
                    stack_order[wrap_idx(k)] = stack_order[wrap_idx(k - 1)];
                    layer_height[stack_order[wrap_idx(k)]] = k;
                end
                stack_order[wrap_idx(h)] = s;
            end else begin
                for (k = prev; k < top_layer; k++) begin
                    stack_order[wrap_idx(k)] = stack_order[wrap_idx(k + 1)];
                    layer_height[stack_order[wrap_idx(k)]] = k;
                end
                top_layer--;
            end
        end else if (prev < h) begin
            if (prev >= 0) begin
                for (k = prev; k < h; k++) begin
                    stack_order[wrap_idx(k)] = stack_order[wrap_idx(k + 1)];
                    layer_height[stack_order[wrap_idx(k)]] = k;
                end
                stack_order[wrap_idx(h)] = s;
            end else begin
                // A hidden layer being shown pushes everything from the target upwards.
                for (k = top_layer; k >= h; k--) begin
                    stack_order[wrap_idx(k + 1)] = stack_order[wrap_idx(k)];
                    layer_height[stack_order[wrap_idx(k + 1)]] = k + 1;
                end
                stack_order[wrap_idx(h)] = s;
                top_layer++;
            end
        end
    endfunction

    function automatic t_layer_result predict_layer_op(t_op op, logic [SLOT_W-1:0] slot,
                                                       logic signed [HREQ_W-1:0] hreq);
        t_layer_result r;
        int s;
        int req;
        int hout;
        int vis;
        int i;
        bit in_use;
        bit found;
        s = slot;
        req = hreq;
        hout = -1;
        r.status = 1'b0;
        in_use = pool_used[s];
        case (op)
            OP_ALLOC: begin
                found = 1'b0;
                s = 0;
                for (i = 0; i < POOL_SIZE; i++) begin
                    if (!found && !pool_used[i]) begin
                        found = 1'b1;
                        pool_used[i] = 1'b1;
                        layer_height[i] = -1;
                        s = i;
                    end
                end
                r.status = !found;
            end
            OP_SET_HEIGHT: begin
                if (in_use) begin
                    move_layer(s, req);
                    hout = layer_height[s];
                end
            end
            OP_FREE: begin
                if (in_use) begin
                    if (layer_height[s] >= 0) move_layer(s, -1);
                    pool_used[s] = 1'b0;
                end
            end
            default: begin
                if (in_use) hout = layer_height[s];
            end
        endcase
        vis = top_layer + 1;
        r.slot = s[SLOT_W-1:0];
        r.height = hout[HOUT_W-1:0];
        r.visible = vis[VIS_W-1:0];
        return r;
    endfunction

    function automatic int layers_in_use();
        int n;
        n = 0;
        for (int i = 0; i < POOL_SIZE; i++) n += pool_used[i];
        return n;
    endfunction

    // Mostly a slot that is in use, now and then any slot at all.
    function automatic logic [SLOT_W-1:0] pick_slot();
        int n;
        int k;
        logic [SLOT_W-1:0] s;
        n = layers_in_use();
        s = SLOT_W'($urandom_range(0, POOL_SIZE - 1));
        if (n > 0 && $urandom_range(0, 99) < 85) begin
            k = $urandom_range(0, n - 1);
            for (int i = 0; i < POOL_SIZE; i++) begin
                if (pool_used[i]) begin
                    if (k == 0) s = i[SLOT_W-1:0];
                    k--;
                end
            end
        end
        return s;
    endfunction

    function automatic logic signed [HREQ_W-1:0] to_hreq(int v);
        return v[HREQ_W-1:0];
    endfunction

    function automatic logic signed [HREQ_W-1:0] pick_height();
        int v;
        case ($urandom_range(0, 9))
            0: v = -1;
            1: v = int'($urandom_range(0, 1023)) - 512;
            2: v = $urandom_range(0, 1) ? 511 : -512;
            3: v = top_layer + int'($urandom_range(0, 1));
            4: v = -2 - int'($urandom_range(0, 20));
            default: v = $urandom_range(0, top_layer + 1);
        endcase
        return to_hreq(v);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch in %s: got %0d, expected %0d (cycle %0d)",
                     what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_op(t_op op, logic [SLOT_W-1:0] slot, logic signed [HREQ_W-1:0] hreq);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            op_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        op_if.valid      <= 1'b1;
        op_if.op         <= op;
        op_if.slot       <= slot;
        op_if.height_req <= hreq;
        do @(posedge i_clk); while (!op_if.ready);
        pending_results.push_back(predict_layer_op(op, slot, hreq));
        @(negedge i_clk);
    endtask

    task automatic wait_results_done();
        op_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_op(OP_QUERY, 8'd0, to_hreq(0));
        send_op(OP_SET_HEIGHT, 8'd5, to_hreq(3));
        send_op(OP_FREE, 8'd255, to_hreq(-1));
        send_op(OP_ALLOC, 8'd0, to_hreq(0));
        send_op(OP_ALLOC, 8'd0, to_hreq(0));
        send_op(OP_ALLOC, 8'd0, to_hreq(0));
        send_op(OP_QUERY, 8'd1, to_hreq(0));
        send_op(OP_SET_HEIGHT, 8'd0, to_hreq(511));
        send_op(OP_SET_HEIGHT, 8'd1, to_hreq(0));
        send_op(OP_SET_HEIGHT, 8'd2, to_hreq(-512));
        send_op(OP_SET_HEIGHT, 8'd2, to_hreq(1));
        // A shown layer raised past the top stops at the top.
        send_op(OP_SET_HEIGHT, 8'd1, to_hreq(511));
        send_op(OP_SET_HEIGHT, 8'd1, to_hreq(0));
        send_op(OP_SET_HEIGHT, 8'd0, to_hreq(-1));
        send_op(OP_QUERY, 8'd0, to_hreq(-512));
        send_op(OP_FREE, 8'd2, to_hreq(0));
        send_op(OP_FREE, 8'd0, to_hreq(0));
        send_op(OP_ALLOC, 8'd255, to_hreq(511));
        send_op(OP_SET_HEIGHT, 8'd0, to_hreq(-2));
        send_op(OP_SET_HEIGHT, 8'd3, to_hreq(100));
        send_op(OP_QUERY, 8'd255, to_hreq(-1));
        send_op(OP_FREE, 8'd1, to_hreq(0));
        send_op(OP_FREE, 8'd0, to_hreq(0));
        wait_results_done();
    endtask

    // Fill the pool, fail one allocation, show every layer, then send frees for an eighth of the pool.
    task automatic test_pool_exhaustion();
        repeat (POOL_SIZE) send_op(OP_ALLOC, pick_slot(), pick_height());
        send_op(OP_ALLOC, pick_slot(), pick_height());
        for (int k = 0; k < POOL_SIZE; k++) begin
            if (k % 16 == 15)
                send_op(OP_SET_HEIGHT, k[SLOT_W-1:0], to_hreq(511));
            else
                send_op(OP_SET_HEIGHT, k[SLOT_W-1:0],
                        to_hreq($urandom_range(0, top_layer + 1)));
        end
        send_op(OP_QUERY, pick_slot(), to_hreq(0));
        send_op(OP_SET_HEIGHT, pick_slot(), to_hreq(511));
        send_op(OP_SET_HEIGHT, pick_slot(), to_hreq(0));
        send_op(OP_SET_HEIGHT, pick_slot(), to_hreq(-512));
        send_op(OP_ALLOC, pick_slot(), pick_height());
        repeat (POOL_SIZE / 8) send_op(OP_FREE, pick_slot(), pick_height());
        wait_results_done();
    endtask

    task automatic run_random_ops(int n_ops, int target_used);
        int r;
        t_op op;
        repeat (n_ops) begin
            r = $urandom_range(0, 99);
            if (layers_in_use() < target_used)
                op = (r < 30) ? OP_ALLOC : (r < 80) ? OP_SET_HEIGHT :
                     (r < 90) ? OP_FREE : OP_QUERY;
            else
                op = (r < 8) ? OP_ALLOC : (r < 63) ? OP_SET_HEIGHT :
                     (r < 90) ? OP_FREE : OP_QUERY;
            send_op(op, pick_slot(), pick_height());
        end
        wait_results_done();
    endtask

    // The receiver holds off while the sender keeps offering, so the block backs up.
    task automatic test_output_backpressure();
        stall_request = 1'b1;
        repeat (8) send_op(OP_SET_HEIGHT, pick_slot(), pick_height());
        wait_results_done();
    endtask

    initial begin
        int hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_request) begin
                hold_left = STALL_LEN;
                stall_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result transfer", 1, 0);
            end else begin
                oldest_expected = pending_results.pop_front();
                if (res_if.slot_out !== oldest_expected.slot)
                    report_mismatch("slot_out", res_if.slot_out, oldest_expected.slot);
                if (res_if.status !== oldest_expected.status)
                    report_mismatch("status", res_if.status, oldest_expected.status);
                if (res_if.height_out !== oldest_expected.height)
                    report_mismatch("height_out", res_if.height_out,
                                    $signed(oldest_expected.height));
                if (res_if.visible_count !== oldest_expected.visible)
                    report_mismatch("visible_count", res_if.visible_count,
                                    oldest_expected.visible);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        op_if.valid      <= 1'b0;
        op_if.op         <= OP_ALLOC;
        op_if.slot       <= '0;
        op_if.height_req <= '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle_pct = 36;
        rcv_idle_pct = 80;
        test_directed();
        test_pool_exhaustion();
        run_random_ops(25, $urandom_range(100, 160));

        snd_idle_pct = 80;
        rcv_idle_pct = 36;
        run_random_ops(25, $urandom_range(8, 40));

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_random_ops(30, $urandom_range(20, 220));
        test_output_backpressure();

        repeat (POOL_SIZE + 8) @(negedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
